// ===== hw/rtl/oaie_pkg.sv =====
package oaie_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = 4;
  localparam int unsigned CMPW = (CW > PW) ? CW : PW;
  localparam int unsigned FW = 5;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5,
    OP_CLEAR  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_INS   = 2'd1,
    CELL_ERA   = 2'd2,
    CELL_WR    = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [PW-1:0]      position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [FW-1:0]      fill_count;
    logic               is_empty;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    cell_op_e           kind;
    logic [CMPW-1:0]    pos;
    logic [CMPW-1:0]    cnt;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/ordered_array_insert_erase.sv =====
// Ordered array of signed 32-bit words with a fill count, held in a row of
// entry cells that shift together. A transaction is accepted on every clock
// edge where start is high, since busy stays low, and its result appears on
// rsp_o with done_o high for exactly the next cycle, so one transaction
// completes per cycle. The receiver cannot stall, and results are lost if
// they are not taken in that cycle. Failed operations report full, range or
// empty status and change nothing. Entries are undefined until written.
module ordered_array_insert_erase (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  oaie_pkg::req_t req_i,
  output logic           done_o,
  output oaie_pkg::rsp_t rsp_o
);

  logic                      accept;
  oaie_pkg::cell_ctl_t       ctl;
  logic [oaie_pkg::CW-1:0]   count;
  logic [oaie_pkg::CW-1:0]   count_next;
  logic                      rd_en;
  oaie_pkg::status_e         status;
  logic signed [31:0]        ent [oaie_pkg::CAPACITY];
  logic signed [31:0]        rd_val;
  logic                      done_q;
  oaie_pkg::rsp_t            rsp_q;
  oaie_pkg::rsp_t            rsp_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  oaie_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_i        (req_i),
    .ctl_o        (ctl),
    .count_o      (count),
    .count_next_o (count_next),
    .rd_en_o      (rd_en),
    .status_o     (status)
  );

  for (genvar i = 0; i < oaie_pkg::CAPACITY; i++) begin : g_cell
    logic signed [31:0] prev;
    logic signed [31:0] next;
    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid
      assign prev = ent[i-1];
    end
    if (i == oaie_pkg::CAPACITY - 1) begin : g_last
      assign next = '0;
    end else begin : g_body
      assign next = ent[i+1];
    end
    oaie_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (oaie_pkg::CMPW'(i)),
      .ctl_i   (ctl),
      .prev_i  (prev),
      .next_i  (next),
      .entry_o (ent[i])
    );
  end

  assign rd_val = rd_en ? ent[oaie_pkg::IW'(req_i.position)] : '0;

  always_comb begin
    rsp_d.read_value = rd_val;
    rsp_d.fill_count = oaie_pkg::FW'(count_next);
    rsp_d.is_empty   = count_next == '0;
    rsp_d.status     = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o) else $error("Accepted transaction produced no result.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o) else $error("Result without an accepted transaction.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= oaie_pkg::CW'(oaie_pkg::CAPACITY)) else $error("Fill count above capacity.");

  a_fail_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != oaie_pkg::ST_OK) |->
      (count == $past(count))) else $error("Failed transaction changed the count.");

  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.read_value != '0) |->
      ($past(req_i.op) == oaie_pkg::OP_READ)) else $error("Read value on a non-read.");

endmodule

// ===== hw/rtl/oaie_cell.sv =====
module oaie_cell (
  input  logic                        clk_i,
  input  logic [oaie_pkg::CMPW-1:0]   idx_i,
  input  oaie_pkg::cell_ctl_t         ctl_i,
  input  logic signed [31:0]          prev_i,
  input  logic signed [31:0]          next_i,
  output logic signed [31:0]          entry_o
);

  logic signed [31:0] entry_q;
  logic signed [31:0] entry_d;

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.kind)
      oaie_pkg::CELL_INS: begin
        if (idx_i == ctl_i.pos) begin
          entry_d = ctl_i.value;
        end else if ((idx_i > ctl_i.pos) && (idx_i <= ctl_i.cnt)) begin
          entry_d = prev_i;
        end
      end
      oaie_pkg::CELL_ERA: begin
        if ((idx_i >= ctl_i.pos) && ((idx_i + oaie_pkg::CMPW'(1)) < ctl_i.cnt)) begin
          entry_d = next_i;
        end
      end
      oaie_pkg::CELL_WR: begin
        if (idx_i == ctl_i.pos) begin
          entry_d = ctl_i.value;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/oaie_ctrl.sv =====
module oaie_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  oaie_pkg::req_t            req_i,
  output oaie_pkg::cell_ctl_t       ctl_o,
  output logic [oaie_pkg::CW-1:0]   count_o,
  output logic [oaie_pkg::CW-1:0]   count_next_o,
  output logic                      rd_en_o,
  output oaie_pkg::status_e         status_o
);

  logic [oaie_pkg::CW-1:0]   count_q;
  logic [oaie_pkg::CW-1:0]   count_d;
  logic [oaie_pkg::CMPW-1:0] pos_c;
  logic [oaie_pkg::CMPW-1:0] cnt_c;
  logic                      full;
  logic                      empty;
  oaie_pkg::cell_op_e        kind;
  logic [oaie_pkg::CMPW-1:0] wpos;
  oaie_pkg::status_e         st;
  logic                      rd_en;

  assign pos_c = oaie_pkg::CMPW'(req_i.position);
  assign cnt_c = oaie_pkg::CMPW'(count_q);
  assign full  = count_q >= oaie_pkg::CW'(oaie_pkg::CAPACITY);
  assign empty = count_q == '0;

  always_comb begin
    kind    = oaie_pkg::CELL_HOLD;
    wpos    = pos_c;
    st      = oaie_pkg::ST_OK;
    count_d = count_q;
    rd_en   = 1'b0;
    case (oaie_pkg::op_e'(req_i.op))
      oaie_pkg::OP_APPEND: begin
        if (full) begin
          st = oaie_pkg::ST_FULL;
        end else begin
          kind    = oaie_pkg::CELL_INS;
          wpos    = cnt_c;
          count_d = count_q + oaie_pkg::CW'(1);
        end
      end
      oaie_pkg::OP_REMOVE: begin
        if (empty) begin
          st = oaie_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - oaie_pkg::CW'(1);
        end
      end
      oaie_pkg::OP_INSERT: begin
        if (full) begin
          st = oaie_pkg::ST_FULL;
        end else if (pos_c > cnt_c) begin
          st = oaie_pkg::ST_RANGE;
        end else begin
          kind    = oaie_pkg::CELL_INS;
          count_d = count_q + oaie_pkg::CW'(1);
        end
      end
      oaie_pkg::OP_ERASE: begin
        if (empty) begin
          st = oaie_pkg::ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          st = oaie_pkg::ST_RANGE;
        end else begin
          kind    = oaie_pkg::CELL_ERA;
          count_d = count_q - oaie_pkg::CW'(1);
        end
      end
      oaie_pkg::OP_READ: begin
        if (pos_c >= cnt_c) begin
          st = oaie_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      oaie_pkg::OP_WRITE: begin
        if (pos_c >= cnt_c) begin
          st = oaie_pkg::ST_RANGE;
        end else begin
          kind = oaie_pkg::CELL_WR;
        end
      end
      oaie_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        st = oaie_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign ctl_o.kind    = accept_i ? kind : oaie_pkg::CELL_HOLD;
  assign ctl_o.pos     = wpos;
  assign ctl_o.cnt     = cnt_c;
  assign ctl_o.value   = req_i.value;
  assign count_o       = count_q;
  assign count_next_o  = count_d;
  assign rd_en_o       = rd_en;
  assign status_o      = st;

endmodule
